>>> rtl/eeqc_pkg.sv
// ============================================================================
// eeqc_pkg
// Shared constants, codes and types of the engine event queue consolidator.
// ============================================================================
package eeqc_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH     = 16;
    localparam int ADJUST_CHANNELS = 8;
    localparam int PTR_W           = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SLOT_DEPTH      = 2 * QUEUE_DEPTH;
    localparam int SLOT_ADDR_W     = $clog2(SLOT_DEPTH);

    // Configuration register file
    localparam int          CFG_ADDR_W       = 3;
    localparam logic        REG_TICK_SCALE   = 1'b0;
    localparam logic [7:0]  TICK_SCALE_RESET = 8'd20;

    // Command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_DRAIN  = 2'd1;
    localparam logic [1:0] CMD_ADJUST = 2'd2;

    // Action code that sets bits; all other codes clear them
    localparam logic [1:0] ACTION_SET = 2'd1;

    // Channel codes
    localparam logic CH_FUEL = 1'b0;
    localparam logic CH_IGN  = 1'b1;

    // One queued event as held in the slot memory
    typedef struct packed {
        logic        sets;
        logic [31:0] time_us;
        logic [31:0] mask;
    } slot_t;

    // Advance a ring pointer with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Slot memory address of a pointer in a given channel's queue.
    function automatic logic [SLOT_ADDR_W-1:0] slot_addr(input logic ch,
                                                          input logic [PTR_W-1:0] p);
        logic [SLOT_ADDR_W-1:0] a;
        if (ch)
        begin
            a = SLOT_ADDR_W'(QUEUE_DEPTH) + SLOT_ADDR_W'(p);
        end
        else
        begin
            a = SLOT_ADDR_W'(p);
        end
        return a;
    endfunction

endpackage

>>> rtl/eeqc_ram.sv
// ============================================================================
// eeqc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module eeqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/engine_event_queue_consolidator.sv
// ============================================================================
// engine_event_queue_consolidator
// Two ring queues of timed fuel and ignition events with output bitmask update.
// ============================================================================
// Push and adjust commands are accepted whenever the block is idle, so they may
// follow one another back to back. A drain is accepted and then, for every event
// it pops, passes through select and memory read, bitmask and time update, and
// delay multiply into the output register, which waits for the sink while a
// result is still held; a drain that pops nothing returns to idle from select.
// The pace is set by the single read port of the slot memory, shared by both
// queues, and by the sequencer that visits the fuel queue before the ignition
// queue. Both queues live in one memory of 2*QUEUE_DEPTH entries; each queue
// holds at most QUEUE_DEPTH-1 events and further pushes are dropped.
module engine_event_queue_consolidator
    import eeqc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: event_mask[31:0], event_time_us[63:32], action_code[65:64],
    //          target_index[68:66], fuel_sink_busy[69], ign_sink_busy[70], zero[71]
    input  logic [71:0]           s_tdata,
    // s_tuser: cmd[1:0], channel[2]
    input  logic [2:0]            s_tuser,
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: pin_mask[31:0], tick_delay[63:32]
    output logic [63:0]           m_tdata,
    // m_tuser: out_channel[0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEL  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_MUL  = 4'b1000
    } state_t;

    // Input field unpacking
    logic [1:0]  in_cmd;
    logic        in_channel;
    logic [31:0] in_mask;
    logic [31:0] in_time;
    logic [1:0]  in_action;
    logic [2:0]  in_target;
    logic        in_fuel_busy;
    logic        in_ign_busy;

    assign in_mask      = s_tdata[31:0];
    assign in_time      = s_tdata[63:32];
    assign in_action    = s_tdata[65:64];
    assign in_target    = s_tdata[68:66];
    assign in_fuel_busy = s_tdata[69];
    assign in_ign_busy  = s_tdata[70];
    assign in_cmd       = s_tuser[1:0];
    assign in_channel   = s_tuser[2];

    // Registers
    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg [2];
    logic [PTR_W-1:0] head_next [2];
    logic [PTR_W-1:0] tail_reg [2];
    logic [PTR_W-1:0] tail_next [2];
    logic [31:0]      bits_reg [2];
    logic [31:0]      bits_next [2];
    logic [31:0]      prev_reg [2];
    logic [31:0]      prev_next [2];
    logic [1:0]       pend_reg, pend_next;
    logic             cur_reg, cur_next;
    logic             last_reg, last_next;
    logic [31:0]      dt_reg, dt_next;
    logic [7:0]       tick_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_ch_reg, out_ch_next;
    logic             out_last_reg, out_last_next;
    logic [31:0]      out_pin_reg, out_pin_next;
    logic [31:0]      out_dly_reg, out_dly_next;

    // Slot memory port signals
    logic                   ram_we;
    logic [SLOT_ADDR_W-1:0] ram_waddr;
    slot_t                  ram_wdata;
    logic                   ram_re;
    logic [SLOT_ADDR_W-1:0] ram_raddr;
    slot_t                  ram_rdata;

    eeqc_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration port: always ready, word decode on paddr[2]
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_TICK_SCALE) ? {24'd0, tick_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= TICK_SCALE_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_TICK_SCALE))
        begin
            tick_reg <= pwdata[7:0];
        end
    end

    // Handshake
    logic in_fire;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Push decode: a plain push or an in-range adjust writes one slot unless the queue is full
    logic        push_req;
    logic        push_full;
    logic [31:0] push_mask;
    logic [31:0] push_time;
    logic        push_sets;

    always_comb
    begin
        push_req  = 1'b0;
        push_mask = in_mask;
        push_time = in_time;
        push_sets = (in_action == ACTION_SET);
        case (in_cmd)
            CMD_PUSH:
            begin
                push_req = 1'b1;
            end
            CMD_ADJUST:
            begin
                push_req  = (32'(in_target) < 32'(ADJUST_CHANNELS));
                push_mask = 32'd1 << in_target;
                push_time = {16'd0, in_time[15:0]};
                push_sets = 1'b0;
            end
            default:
            begin
                push_req = 1'b0;
            end
        endcase
    end

    assign push_full = (ptr_inc(head_reg[in_channel]) == tail_reg[in_channel]);

    // Queue readiness for the drain sequencer
    logic fuel_go;
    logic ign_go;

    assign fuel_go = pend_reg[0] && (head_reg[0] != tail_reg[0]);
    assign ign_go  = pend_reg[1] && (head_reg[1] != tail_reg[1]);

    // Sequencer and state update
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        bits_next      = bits_reg;
        prev_next      = prev_reg;
        pend_next      = pend_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        dt_next        = dt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ch_next    = out_ch_reg;
        out_last_next  = out_last_reg;
        out_pin_next   = out_pin_reg;
        out_dly_next   = out_dly_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_addr(in_channel, head_reg[in_channel]);
        ram_wdata      = '{sets: push_sets, time_us: push_time, mask: push_mask};
        ram_re         = 1'b0;
        ram_raddr      = slot_addr(cur_reg, tail_reg[cur_reg]);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == CMD_DRAIN)
                    begin
                        pend_next  = {!in_ign_busy, !in_fuel_busy};
                        state_next = ST_SEL;
                    end
                    else if (push_req && !push_full)
                    begin
                        ram_we                = 1'b1;
                        head_next[in_channel] = ptr_inc(head_reg[in_channel]);
                    end
                end
            end
            ST_SEL:
            begin
                // Fuel queue first, then ignition
                if (fuel_go)
                begin
                    cur_next    = CH_FUEL;
                    last_next   = !ign_go;
                    pend_next[0] = 1'b0;
                    ram_re      = 1'b1;
                    ram_raddr   = slot_addr(CH_FUEL, tail_reg[0]);
                    state_next  = ST_RD;
                end
                else if (ign_go)
                begin
                    cur_next    = CH_IGN;
                    last_next   = 1'b1;
                    pend_next[1] = 1'b0;
                    ram_re      = 1'b1;
                    ram_raddr   = slot_addr(CH_IGN, tail_reg[1]);
                    state_next  = ST_RD;
                end
                else
                begin
                    pend_next  = 2'b00;
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                // Slot data is valid; apply the event to the channel state
                if (ram_rdata.sets)
                begin
                    bits_next[cur_reg] = bits_reg[cur_reg] | ram_rdata.mask;
                end
                else
                begin
                    bits_next[cur_reg] = bits_reg[cur_reg] & ~ram_rdata.mask;
                end
                dt_next            = ram_rdata.time_us - prev_reg[cur_reg];
                prev_next[cur_reg] = ram_rdata.time_us;
                tail_next[cur_reg] = ptr_inc(tail_reg[cur_reg]);
                state_next         = ST_MUL;
            end
            ST_MUL:
            begin
                // Scale the delay into the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = cur_reg;
                    out_last_next  = last_reg;
                    out_pin_next   = bits_reg[cur_reg];
                    out_dly_next   = dt_reg * {24'd0, tick_reg};
                    state_next     = last_reg ? ST_IDLE : ST_SEL;
                    if (last_reg)
                    begin
                        pend_next = 2'b00;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '{default: '0};
            tail_reg      <= '{default: '0};
            bits_reg      <= '{default: '0};
            prev_reg      <= '{default: '0};
            pend_reg      <= 2'b00;
            cur_reg       <= CH_FUEL;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            bits_reg      <= bits_next;
            prev_reg      <= prev_next;
            pend_reg      <= pend_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
        out_pin_reg  <= out_pin_next;
        out_dly_reg  <= out_dly_next;
    end

    // Output stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dly_reg, out_pin_reg};
    assign m_tuser  = out_ch_reg;
    assign m_tlast  = out_last_reg;

    // Assertions
    // Slots are written only while idle, so a write never meets a pending read.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("slot write outside idle state");

    // A popped queue must have held at least one event when it was selected.
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (head_reg[cur_reg] != tail_reg[cur_reg]))
        else $error("slot read from an empty queue");

    // A fresh result comes only from the multiply step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_MUL))
        else $error("result loaded outside the multiply step");

    // The multiply step waits while a result is still held by the sink.
    a_mul_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL) && m_tvalid && !m_tready) |=> (state_reg == ST_MUL))
        else $error("result overwritten before transaction completed");

endmodule
